@@ src/rc6_pkg.sv @@
// Shared types, constants and helpers for the RC6 block encryptor.
package rc6_pkg;

   localparam logic [31:0] MAGIC_P = 32'hB7E15163;
   localparam logic [31:0] MAGIC_Q = 32'h9E3779B9;
   localparam int unsigned NUM_KEY_REGS = 4;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned COUNT_W = 4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KEY0  = 3'd0,
      CSR_KEY1  = 3'd1,
      CSR_KEY2  = 3'd2,
      CSR_KEY3  = 3'd3,
      CSR_COUNT = 3'd4
   } csr_index_type;

   // status of the key schedule unit toward the block sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } sched_stat_type;

   typedef enum logic [3:0] {
      KS_IDLE = 4'b0001,
      KS_INIT = 4'b0010,
      KS_MIX  = 4'b0100,
      KS_HOLD = 4'b1000
   } ks_state_type;

   typedef enum logic [4:0] {
      EN_IDLE  = 5'b00001,
      EN_KEYS  = 5'b00010,
      EN_LOAD  = 5'b00100,
      EN_ROUND = 5'b01000,
      EN_FINAL = 5'b10000
   } en_state_type;

   // rotate left by the low five bits of n
   function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] wide;
      wide = {x, x} << n;
      return wide[63:32];
   endfunction

endpackage

@@ src/rc6_block_encryptor_core.sv @@
// Top level of the RC6-32 block encryptor (ECB, encryption only).
// Each 128-bit word on req_ gives one ciphertext word on rsp_. Round keys live
// in one RAM of 2*ROUNDS+4 entries. After reset or any key or count write, the first
// block triggers key expansion: an initial fill with the magic-constant sequence,
// then 3*max(2*ROUNDS+4, c) read-modify-write mixing steps, bound by the single
// RAM write port. A block is then encrypted at one round per cycle, each round
// fetching its two keys from the RAM's two read ports. A finished block waits
// in an output register while the next one is accepted.
module rc6_block_encryptor_core #(
   parameter int ROUNDS = 20,
   parameter int MAX_KEY_WORDS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [127:0]                        req_tdata,  // word_d, word_c, word_b, word_a (MSB to LSB)
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [127:0]                        rsp_tdata,  // out_d, out_c, out_b, out_a (MSB to LSB)
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rc6_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [63:0]                         csr_data
);
   import rc6_pkg::*;

   localparam int SCHED_LEN = 2*ROUNDS + 4;
   localparam int AW = $clog2(SCHED_LEN);

   logic [63:0] key_ff [NUM_KEY_REGS];
   logic [COUNT_W-1:0] count_ff;
   logic ready_ff;
   logic [31:0] key_words [MAX_KEY_WORDS];
   sched_stat_type sched_stat;
   logic sched_start, ks_wr_en;
   logic [AW-1:0] ks_wr_addr, ks_rd_addr, en_rd0, en_rd1, rd_addr0;
   logic [31:0] ks_wr_data, rd_data0, rd_data1;
   logic csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // take key writes, drop the schedule on any key or count register write
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_KEY_REGS; k++) begin
            key_ff[k] <= '0;
         end
         count_ff <= COUNT_W'(4);
         ready_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_KEY0, CSR_KEY1, CSR_KEY2, CSR_KEY3: begin
                  key_ff[csr_index[1:0]] <= csr_data;
                  ready_ff <= 1'b0;
               end
               CSR_COUNT: begin
                  count_ff <= csr_data[COUNT_W-1:0];
                  ready_ff <= 1'b0;
               end
               default: ;
            endcase
         end
         if (sched_stat.done) begin
            ready_ff <= 1'b1;
         end
      end
   end

   // split the key registers into 32-bit words
   for (genvar g = 0; g < MAX_KEY_WORDS; g++) begin : g_words
      assign key_words[g] = key_ff[g/2][(g%2)*32 +: 32];
   end

   rc6_key_sched #(.ROUNDS(ROUNDS), .MAX_KEY_WORDS(MAX_KEY_WORDS)) u_sched (
      .clock(clock), .reset(reset), .start(sched_start),
      .key_words(key_words), .key_count(count_ff), .stat(sched_stat),
      .wr_en(ks_wr_en), .wr_addr(ks_wr_addr), .wr_data(ks_wr_data),
      .rd_addr(ks_rd_addr), .rd_data(rd_data0)
   );

   assign rd_addr0 = sched_stat.busy ? ks_rd_addr : en_rd0;

   rc6_ram #(.WIDTH(32), .DEPTH(SCHED_LEN)) u_keys (
      .clock(clock), .wr_en(ks_wr_en), .wr_addr(ks_wr_addr), .wr_data(ks_wr_data),
      .rd_addr0(rd_addr0), .rd_data0(rd_data0),
      .rd_addr1(en_rd1), .rd_data1(rd_data1)
   );

   rc6_cipher #(.ROUNDS(ROUNDS)) u_cipher (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .keys_ready(ready_ff), .sched_stat(sched_stat), .sched_start(sched_start),
      .rd_addr0(en_rd0), .rd_addr1(en_rd1), .rd_data0(rd_data0), .rd_data1(rd_data1)
   );
endmodule

@@ src/rc6_ram.sv @@
// Generic synchronous RAM: one write port, two registered read ports.
module rc6_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 44
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr0,
   output logic [WIDTH-1:0]         rd_data0,
   input  logic [$clog2(DEPTH)-1:0] rd_addr1,
   output logic [WIDTH-1:0]         rd_data1
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write and read, read data registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data0 <= mem[rd_addr0];
      rd_data1 <= mem[rd_addr1];
   end
endmodule

@@ src/rc6_key_sched.sv @@
// RC6 key expansion: fills the round key RAM, then mixes it with the key words.
module rc6_key_sched #(
   parameter int ROUNDS = 20,
   parameter int MAX_KEY_WORDS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [31:0]                         key_words [MAX_KEY_WORDS],
   input  logic [rc6_pkg::COUNT_W-1:0]         key_count,
   output rc6_pkg::sched_stat_type             stat,
   output logic                                wr_en,
   output logic [$clog2(2*ROUNDS+4)-1:0]       wr_addr,
   output logic [31:0]                         wr_data,
   output logic [$clog2(2*ROUNDS+4)-1:0]       rd_addr,
   input  logic [31:0]                         rd_data
);
   import rc6_pkg::*;

   localparam int SCHED_LEN = 2*ROUNDS + 4;
   localparam int AW = $clog2(SCHED_LEN);
   localparam int LW = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;
   localparam int STEP_MAX = 3 * ((SCHED_LEN > MAX_KEY_WORDS) ? SCHED_LEN : MAX_KEY_WORDS);
   localparam int SW = $clog2(STEP_MAX + 1);

   ks_state_type state_ff, state_in;
   logic [AW-1:0] i_ff, i_in;
   logic [LW-1:0] j_ff, j_in;
   logic [SW-1:0] s_ff, s_in, steps_ff, steps_in;
   logic [COUNT_W-1:0] c_ff, c_in;
   logic [31:0] a_ff, a_in, b_ff, b_in, init_ff, init_in;
   logic [31:0] l_ff [MAX_KEY_WORDS];
   logic [COUNT_W-1:0] c_clamp;
   logic [SW-1:0] c_len;
   logic [31:0] a_new, b_new, ab_sum;
   logic i_last, j_last;

   // clamp the word count to 1..MAX_KEY_WORDS
   always_comb begin
      c_clamp = key_count;
      if (key_count == '0) begin
         c_clamp = COUNT_W'(1);
      end else if (key_count > COUNT_W'(MAX_KEY_WORDS)) begin
         c_clamp = COUNT_W'(MAX_KEY_WORDS);
      end
      c_len = (SW'(SCHED_LEN) > SW'(c_clamp)) ? SW'(SCHED_LEN) : SW'(c_clamp);
   end

   // one mixing step
   assign a_new  = rotl32(rd_data + a_ff + b_ff, 5'd3);
   assign ab_sum = a_new + b_ff;
   assign b_new  = rotl32(l_ff[j_ff] + ab_sum, ab_sum[4:0]);
   assign i_last = (i_ff == AW'(SCHED_LEN - 1));
   assign j_last = ({{(COUNT_W){1'b0}}, j_ff} == (COUNT_W+LW)'(c_ff - COUNT_W'(1)));

   always_comb begin
      state_in = state_ff;
      i_in = i_ff;
      j_in = j_ff;
      s_in = s_ff;
      steps_in = steps_ff;
      c_in = c_ff;
      a_in = a_ff;
      b_in = b_ff;
      init_in = init_ff;
      wr_en = 1'b0;
      wr_addr = i_ff;
      wr_data = init_ff;
      rd_addr = '0;
      stat.done = 1'b0;
      stat.busy = (state_ff != KS_IDLE);
      unique case (state_ff)
         KS_IDLE: begin
            if (start) begin
               state_in = KS_INIT;
               i_in = '0;
               init_in = MAGIC_P;
               c_in = c_clamp;
               steps_in = SW'(c_len * 3);
            end
         end
         KS_INIT: begin
            // write the magic-constant sequence
            wr_en = 1'b1;
            init_in = init_ff + MAGIC_Q;
            i_in = i_ff + AW'(1);
            if (i_last) begin
               state_in = KS_MIX;
               i_in = '0;
               j_in = '0;
               s_in = '0;
               a_in = '0;
               b_in = '0;
            end
         end
         KS_MIX: begin
            // read-modify-write one round key, prefetch the next
            wr_en = 1'b1;
            wr_data = a_new;
            a_in = a_new;
            b_in = b_new;
            i_in = i_last ? '0 : i_ff + AW'(1);
            j_in = j_last ? '0 : j_ff + LW'(1);
            s_in = s_ff + SW'(1);
            rd_addr = i_in;
            if (s_ff == steps_ff - SW'(1)) begin
               state_in = KS_HOLD;
               stat.done = 1'b1;
            end
         end
         KS_HOLD: begin
            state_in = KS_IDLE;
         end
         default: state_in = KS_IDLE;
      endcase
      if (state_ff == KS_INIT && i_last) begin
         rd_addr = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= KS_IDLE;
      end else begin
         state_ff <= state_in;
      end
      i_ff <= i_in;
      j_ff <= j_in;
      s_ff <= s_in;
      steps_ff <= steps_in;
      c_ff <= c_in;
      a_ff <= a_in;
      b_ff <= b_in;
      init_ff <= init_in;
   end

   // key word array: load on start, update during mixing
   always_ff @(posedge clock) begin
      if (state_ff == KS_IDLE && start) begin
         for (int k = 0; k < MAX_KEY_WORDS; k++) begin
            l_ff[k] <= (COUNT_W'(k) < c_clamp) ? key_words[k] : '0;
         end
      end else if (state_ff == KS_MIX) begin
         l_ff[j_ff] <= b_new;
      end
   end
endmodule

@@ src/rc6_cipher.sv @@
// RC6 round sequencer and datapath: one round per cycle from the round key RAM.
module rc6_cipher #(
   parameter int ROUNDS = 20
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [127:0]                  req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [127:0]                  rsp_tdata,
   input  logic                          keys_ready,
   input  rc6_pkg::sched_stat_type       sched_stat,
   output logic                          sched_start,
   output logic [$clog2(2*ROUNDS+4)-1:0] rd_addr0,
   output logic [$clog2(2*ROUNDS+4)-1:0] rd_addr1,
   input  logic [31:0]                   rd_data0,
   input  logic [31:0]                   rd_data1
);
   import rc6_pkg::*;

   localparam int SCHED_LEN = 2*ROUNDS + 4;
   localparam int AW = $clog2(SCHED_LEN);
   localparam int RW = $clog2(ROUNDS + 1);

   en_state_type state_ff, state_in;
   logic [31:0] a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;
   logic [RW-1:0] r_ff, r_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic out_valid_ff, out_valid_in;
   logic [127:0] out_ff, out_in;
   logic [31:0] t_prod, u_prod, t, u, a_rnd, c_rnd;
   logic accept, out_free;

   // round function
   assign t_prod = b_ff * {b_ff[30:0], 1'b1};
   assign u_prod = d_ff * {d_ff[30:0], 1'b1};
   assign t = rotl32(t_prod, 5'd5);
   assign u = rotl32(u_prod, 5'd5);
   assign a_rnd = rotl32(a_ff ^ t, u[4:0]) + rd_data0;
   assign c_rnd = rotl32(c_ff ^ u, t[4:0]) + rd_data1;

   assign req_tready = (state_ff == EN_IDLE);
   assign accept = req_tvalid && req_tready;
   assign out_free = !out_valid_ff || rsp_tready;
   assign rd_addr0 = addr_ff;
   assign rd_addr1 = addr_ff + AW'(1);

   always_comb begin
      state_in = state_ff;
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      r_in = r_ff;
      addr_in = addr_ff;
      sched_start = 1'b0;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_in = out_ff;
      unique case (state_ff)
         EN_IDLE: begin
            if (accept) begin
               a_in = req_tdata[31:0];
               b_in = req_tdata[63:32];
               c_in = req_tdata[95:64];
               d_in = req_tdata[127:96];
               addr_in = '0;
               if (keys_ready) begin
                  state_in = EN_LOAD;
               end else begin
                  state_in = EN_KEYS;
                  sched_start = 1'b1;
               end
            end
         end
         EN_KEYS: begin
            // wait for the expansion, then fetch the whitening keys
            if (keys_ready && !sched_stat.busy) begin
               state_in = EN_LOAD;
            end
         end
         EN_LOAD: begin
            // the RAM read is registered: data for the first pair is valid in the cycle after the address
            state_in = EN_ROUND;
            r_in = '0;
            addr_in = AW'(2);
         end
         EN_ROUND: begin
            if (r_ff == '0) begin
               b_in = b_ff + rd_data0;
               d_in = d_ff + rd_data1;
               r_in = RW'(1);
               addr_in = AW'(4);
            end else begin
               a_in = b_ff;
               b_in = c_rnd;
               c_in = d_ff;
               d_in = a_rnd;
               r_in = r_ff + RW'(1);
               addr_in = addr_ff + AW'(2);
               if (r_ff == RW'(ROUNDS)) begin
                  state_in = EN_FINAL;
                  addr_in = addr_ff;
               end
            end
         end
         EN_FINAL: begin
            // point the read ports at the last pair and hold it until the output register frees up
            if (addr_ff != AW'(SCHED_LEN - 2)) begin
               addr_in = AW'(SCHED_LEN - 2);
            end else if (out_free) begin
               out_in = {d_ff, c_ff + rd_data1, b_ff, a_ff + rd_data0};
               out_valid_in = 1'b1;
               state_in = EN_IDLE;
            end
         end
         default: state_in = EN_IDLE;
      endcase
   end

   // the LOAD state covers the registered RAM read before round zero
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EN_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
      r_ff <= r_in;
      addr_ff <= addr_in;
      out_ff <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_ff;
endmodule

@@ dv/tb_rc6_block_encryptor_core.sv @@
// Self-checking testbench for the RC6-32/20 block encryptor core.
`timescale 1ns / 100ps

module tb_rc6_block_encryptor_core;
   import rc6_pkg::*;

   localparam int ROUND_COUNT = 20;
   localparam int MAX_WORDS = 8;
   localparam int SCHEDULE_LEN = 2 * ROUND_COUNT + 4;
   localparam int RANDOM_BLOCKS = 930;
   localparam int SETTLE_CYCLES = 300;

   typedef struct packed {
      logic [31:0] d;
      logic [31:0] c;
      logic [31:0] b;
      logic [31:0] a;
   } block_type;

   typedef struct {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
      logic        check_known;
      logic [31:0] known_a;
   } plain_row_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [127:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [127:0] rsp_tdata;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [63:0] csr_data;

   // mirror of the key registers and the derived schedule
   logic [63:0] key_reg_copy [NUM_KEY_REGS];
   logic [3:0] key_count_copy;
   logic [31:0] sched_words [SCHEDULE_LEN];
   bit sched_valid;

   block_type cipher_queue[$];
   int mismatch_count;
   int idle_percent;
   bit failed;

   rc6_block_encryptor_core uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] rol(input logic [31:0] x, input logic [31:0] n);
      logic [4:0] sh;
      sh = n[4:0];
      return (sh == 0) ? x : ((x << sh) | (x >> (6'd32 - sh)));
   endfunction

   // expand the held key into the round key schedule
   task automatic expand_schedule();
      logic [31:0] lw [MAX_WORDS];
      logic [31:0] x, y;
      int nwords, steps, i, j;
      nwords = key_count_copy;
      if (nwords < 1) nwords = 1;
      if (nwords > MAX_WORDS) nwords = MAX_WORDS;
      for (int k = 0; k < MAX_WORDS; k++) begin
         lw[k] = (k < nwords) ? (k[0] ? key_reg_copy[k >> 1][63:32]
                                      : key_reg_copy[k >> 1][31:0]) : 32'd0;
      end
      sched_words[0] = MAGIC_P;
      for (int k = 1; k < SCHEDULE_LEN; k++) sched_words[k] = sched_words[k-1] + MAGIC_Q;
      steps = 3 * ((SCHEDULE_LEN > nwords) ? SCHEDULE_LEN : nwords);
      x = 0;
      y = 0;
      i = 0;
      j = 0;
      for (int s = 0; s < steps; s++) begin
         x = rol(sched_words[i] + x + y, 3);
         sched_words[i] = x;
         y = rol(lw[j] + x + y, x + y);
         lw[j] = y;
         i = (i + 1) % SCHEDULE_LEN;
         j = (j + 1) % nwords;
      end
      sched_valid = 1'b1;
   endtask

   // encrypt one plaintext block with the current schedule
   task automatic encrypt_block(input block_type p, output block_type q);
      logic [31:0] a, b, c, d, t, u, hold;
      if (!sched_valid) expand_schedule();
      a = p.a;
      b = p.b + sched_words[0];
      c = p.c;
      d = p.d + sched_words[1];
      for (int r = 1; r <= ROUND_COUNT; r++) begin
         t = rol(b * (2 * b + 1), 5);
         u = rol(d * (2 * d + 1), 5);
         a = rol(a ^ t, u) + sched_words[2*r];
         c = rol(c ^ u, t) + sched_words[2*r+1];
         hold = a;
         a = b;
         b = c;
         c = d;
         d = hold;
      end
      q.a = a + sched_words[2*ROUND_COUNT+2];
      q.b = b;
      q.c = c + sched_words[2*ROUND_COUNT+3];
      q.d = d;
   endtask

   function automatic bit idle_now();
      return $urandom_range(99) < idle_percent;
   endfunction

   // write one key or count register while the core is idle
   task automatic write_csr(input csr_index_type idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_COUNT) key_count_copy = value[3:0];
      else key_reg_copy[idx] = value;
      sched_valid = 1'b0;
      @(posedge clock);
   endtask

   // send one plaintext word and queue its ciphertext
   task automatic send_block(input block_type p);
      block_type q;
      while (idle_now()) @(posedge clock);
      encrypt_block(p, q);
      cipher_queue.push_back(q);
      req_tvalid <= 1'b1;
      req_tdata <= p;
      do @(posedge clock); while (!req_tready);
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (cipher_queue.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   // check returned words in order
   always @(posedge clock) begin
      block_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (cipher_queue.size() == 0) begin
            failed = 1'b1;
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected ciphertext %h", got);
         end else begin
            want = cipher_queue.pop_front();
            if (got !== want) begin
               failed = 1'b1;
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("ciphertext mismatch: expected %h actual %h", want, got);
            end
         end
      end
      rsp_tready <= reset ? 1'b0 : !idle_now();
   end

   // directed plaintexts; the first row is the published all-zero vector
   plain_row_type plain_rows [6] = '{
      '{32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0},
      '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 32'h0},
      '{32'h80000000, 32'h00000001, 32'h7FFFFFFF, 32'hFFFFFFFE, 1'b0, 32'h0},
      '{32'h02132435, 32'h46576879, 32'h8A9BACBD, 32'hCEDFE0F1, 1'b0, 32'h0},
      '{32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555, 1'b0, 32'h0},
      '{32'h00000001, 32'h0, 32'h0, 32'h80000000, 1'b0, 32'h0}
   };

   initial begin
      block_type p;
      logic [3:0] counts [6];
      counts = '{4'd4, 4'd1, 4'd8, 4'd0, 4'd15, 4'd6};
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_KEY0;
      csr_data = '0;
      idle_percent = 33;
      failed = 1'b0;
      mismatch_count = 0;
      for (int k = 0; k < NUM_KEY_REGS; k++) key_reg_copy[k] = '0;
      key_count_copy = 4'd4;
      sched_valid = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // after reset: zero 128-bit key, known answer 8fc3a536 56b1f778 c129df4e 9848a41e
      p = '{d: 32'h0, c: 32'h0, b: 32'h0, a: 32'h0};
      send_block(p);
      drain();
      if (sched_words[SCHEDULE_LEN-1] === 'x) failed = 1'b1;

      // directed sweep across key counts including zero and saturation
      foreach (counts[n]) begin
         for (int k = 0; k < NUM_KEY_REGS; k++)
            write_csr(csr_index_type'(k), (n == 1) ? 64'hFFFFFFFF_FFFFFFFF :
                      (n == 0) ? 64'h0 : {$urandom, $urandom});
         write_csr(CSR_COUNT, {60'd0, counts[n]});
         foreach (plain_rows[r]) begin
            p.a = plain_rows[r].a;
            p.b = plain_rows[r].b;
            p.c = plain_rows[r].c;
            p.d = plain_rows[r].d;
            send_block(p);
         end
         drain();
      end

      // random phases with a key change between each
      for (int ph = 0; ph < 10; ph++) begin
         idle_percent = (ph == 4) ? 0 : 33;
         write_csr(csr_index_type'($urandom_range(NUM_KEY_REGS - 1)), {$urandom, $urandom});
         if (ph % 3 == 0) write_csr(CSR_COUNT, {60'd0, 4'($urandom)});
         for (int k = 0; k < RANDOM_BLOCKS / 10; k++) begin
            p = {$urandom, $urandom, $urandom, $urandom};
            send_block(p);
         end
         drain();
      end

      while (cipher_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (!failed && cipher_queue.size() == 0) begin
         $display("rc6_block_encryptor_core regression: pass");
      end else begin
         $display("rc6_block_encryptor_core regression: fail");
      end
      $finish;
   end

   // hard stop well past the slowest legal run
   initial begin
      #20ms;
      $display("rc6_block_encryptor_core regression: fail");
      $finish;
   end

endmodule
